### rtl/core/ems_pkg.sv
// Shared types, codes and constants of the encoder move sequencer.
package ems_pkg;

  // Move codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_PIVOT    = 2'd0,
    OP_TURN     = 2'd1,
    OP_STRAIGHT = 2'd2,
    OP_ABORT    = 2'd3
  } op_t;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_CAPTURE = 2'd0,
    PH_DRIVE   = 2'd1,
    PH_BRAKE   = 2'd2,
    PH_FINISH  = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_DRIVE_SPEED   = 2'd0;
  localparam logic [1:0] REG_PIVOT_COUNTS  = 2'd1;
  localparam logic [1:0] REG_TURN_COUNTS   = 2'd2;
  localparam logic [1:0] REG_CM_PER_COUNT  = 2'd3;

  // Register reset values.
  localparam logic [6:0]  DRIVE_SPEED_RST  = 7'd30;
  localparam logic [15:0] PIVOT_COUNTS_RST = 16'd180;
  localparam logic [15:0] TURN_COUNTS_RST  = 16'd170;
  localparam logic [15:0] CM_PER_COUNT_RST = 16'd3204;

  // Largest power magnitude ever commanded.
  localparam logic [6:0]  SPEED_MAX       = 7'd100;
  // Degrees in one quarter turn.
  localparam logic [15:0] DEG_PER_QUARTER = 16'd90;

  // One input beat.
  typedef struct packed {
    op_t                operation;
    logic signed [15:0] target;
    logic               pivot_on_right;
    logic signed [31:0] left_encoder;
    logic signed [31:0] right_encoder;
    logic signed [7:0]  right_power_now;
  } item_t;

  // Configuration register file.
  typedef struct packed {
    logic [6:0]  drive_speed;
    logic [15:0] pivot_counts_per_quarter;
    logic [15:0] turn_counts_per_quarter;
    logic [15:0] cm_per_count_q16;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic signed [7:0] left_power;
    logic signed [7:0] right_power;
    logic              left_brake;
    logic              right_brake;
    logic              done_res;
  } result_t;

  // Encoder that a move measures: the left one only for a pivot about the right wheel.
  function automatic logic signed [31:0] measured_angle(item_t it);
    logic sel_left;
    sel_left = (it.operation == OP_PIVOT) && it.pivot_on_right;
    return sel_left ? it.left_encoder : it.right_encoder;
  endfunction

endpackage

### rtl/core/encoder_move_sequencer.sv
// Top level of the encoder move sequencer: handshake registers and configuration.
// A beat passes the input register, then the result register, on its way to the outputs.
// Throughput: one beat per cycle; the only stall source is out_ready held low.
// Reset (synchronous, active high) empties both registers, returns the phase to
// capture, clears the start angle and loads the register defaults.
module encoder_move_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [15:0] target,
  input  logic               pivot_on_right,
  input  logic signed [31:0] left_encoder,
  input  logic signed [31:0] right_encoder,
  input  logic signed [7:0]  right_power_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  left_power,
  output logic signed [7:0]  right_power,
  output logic               left_brake,
  output logic               right_brake,
  output logic               done_res
);
  import ems_pkg::*;

  cfg_t               cfg;
  item_t              item_q;
  logic               item_vld;
  result_t            result_q;
  result_t            result_d;
  logic               advance;
  logic               step;
  logic               reached;
  logic signed [31:0] start_angle;

  // Result register is free when empty or being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_vld || advance;
  assign step     = item_vld && advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_speed              <= DRIVE_SPEED_RST;
      cfg.pivot_counts_per_quarter <= PIVOT_COUNTS_RST;
      cfg.turn_counts_per_quarter  <= TURN_COUNTS_RST;
      cfg.cm_per_count_q16         <= CM_PER_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DRIVE_SPEED:  cfg.drive_speed              <= cfg_data[6:0];
        REG_PIVOT_COUNTS: cfg.pivot_counts_per_quarter <= cfg_data;
        REG_TURN_COUNTS:  cfg.turn_counts_per_quarter  <= cfg_data;
        REG_CM_PER_COUNT: cfg.cm_per_count_q16         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_ready) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.operation       <= op_t'(operation);
      item_q.target          <= target;
      item_q.pivot_on_right  <= pivot_on_right;
      item_q.left_encoder    <= left_encoder;
      item_q.right_encoder   <= right_encoder;
      item_q.right_power_now <= right_power_now;
    end
  end

  ems_travel u_travel (
    .item        (item_q),
    .cfg         (cfg),
    .start_angle (start_angle),
    .reached     (reached)
  );

  ems_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item_q),
    .cfg         (cfg),
    .reached     (reached),
    .start_angle (start_angle),
    .result      (result_d)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign left_power  = result_q.left_power;
  assign right_power = result_q.right_power;
  assign left_brake  = result_q.left_brake;
  assign right_brake = result_q.right_brake;
  assign done_res    = result_q.done_res;

endmodule

### rtl/core/ems_travel.sv
// Travel measurement and end-of-drive compare for the current move.
module ems_travel (
  input  ems_pkg::item_t    item,
  input  ems_pkg::cfg_t     cfg,
  input  logic signed [31:0] start_angle,
  output logic               reached
);
  import ems_pkg::*;

  logic signed [31:0] measured;
  logic [32:0]        diff;
  logic [32:0]        travel;
  logic [15:0]        mag;
  logic [15:0]        lhs_k;
  logic [15:0]        rhs_k;
  logic [48:0]        lhs;
  logic [31:0]        prod;
  logic [31:0]        rhs;

  // Exact 33-bit distance from the captured start angle.
  always_comb begin
    measured = measured_angle(item);
    diff     = {measured[31], measured} - {start_angle[31], start_angle};
    travel   = diff[32] ? (~diff + 33'd1) : diff;
    mag      = item.target[15] ? 16'(~item.target + 16'sd1) : 16'(item.target);
  end

  // Pivot and turn compare 90 * travel against counts * degrees; straight compares
  // travel * cm_per_count against the target in Q16 centimetres.
  always_comb begin
    lhs_k = (item.operation == OP_STRAIGHT) ? cfg.cm_per_count_q16 : DEG_PER_QUARTER;
    rhs_k = (item.operation == OP_PIVOT) ? cfg.pivot_counts_per_quarter
                                         : cfg.turn_counts_per_quarter;
    lhs   = 49'(travel) * 49'(lhs_k);
    prod  = 32'(rhs_k) * 32'(mag);
    rhs   = (item.operation == OP_STRAIGHT) ? {mag, 16'd0} : prod;
    reached = lhs >= 49'(rhs);
  end

endmodule

### rtl/core/ems_ctrl.sv
// Phase sequencer: phase and start angle registers plus motor command decode.
module ems_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  ems_pkg::item_t     item,
  input  ems_pkg::cfg_t      cfg,
  input  logic               reached,
  output logic signed [31:0] start_angle,
  output ems_pkg::result_t   result
);
  import ems_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [6:0]        speed;
  logic signed [7:0] sd;
  logic signed [7:0] sd_neg;
  logic              is_abort;

  assign is_abort = (item.operation == OP_ABORT);

  // Drive power: clamped speed, positive only for a strictly positive target.
  always_comb begin
    speed  = (cfg.drive_speed > SPEED_MAX) ? SPEED_MAX : cfg.drive_speed;
    sd     = (!item.target[15] && (item.target != 16'sd0)) ? $signed({1'b0, speed})
                                                          : -$signed({1'b0, speed});
    sd_neg = -sd;
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (is_abort) begin
      phase_next = PH_CAPTURE;
    end else begin
      unique case (phase)
        PH_CAPTURE: phase_next = PH_DRIVE;
        PH_DRIVE:   if (reached) phase_next = PH_BRAKE;
        PH_BRAKE:   if (item.right_power_now == 8'sd0) phase_next = PH_FINISH;
        PH_FINISH:  phase_next = PH_CAPTURE;
        default:    phase_next = PH_CAPTURE;
      endcase
    end
  end

  // Motor commands for this beat; every phase but drive holds both brakes.
  always_comb begin
    result             = '0;
    result.left_brake  = 1'b1;
    result.right_brake = 1'b1;
    if (!is_abort) begin
      unique case (phase)
        PH_DRIVE: begin
          case (item.operation)
            OP_PIVOT: begin
              if (item.pivot_on_right) begin
                result.left_power = sd;
                result.left_brake = 1'b0;
              end else begin
                result.right_power = sd;
                result.right_brake = 1'b0;
              end
            end
            OP_TURN: begin
              result.left_power  = sd;
              result.right_power = sd_neg;
              result.left_brake  = 1'b0;
              result.right_brake = 1'b0;
            end
            default: begin
              result.left_power  = sd;
              result.right_power = sd;
              result.left_brake  = 1'b0;
              result.right_brake = 1'b0;
            end
          endcase
        end
        PH_FINISH: result.done_res = 1'b1;
        default:   result.done_res = 1'b0;
      endcase
    end
  end

  // State registers advance once per processed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CAPTURE;
      start_angle <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (phase == PH_CAPTURE && !is_abort) begin
        start_angle <= measured_angle(item);
      end
    end
  end

endmodule

### rtl/core/ems_checker.sv
// Port-level checks of the encoder move sequencer and their binding.
module ems_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] left_power,
  input logic signed [7:0] right_power,
  input logic              left_brake,
  input logic              right_brake,
  input logic              done_res
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_power) && $stable(right_power)
      && $stable(left_brake) && $stable(right_brake) && $stable(done_res))
    else $error("result beat changed while stalled");

  // A braked motor is never given power.
  a_brake_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!left_brake || left_power == 8'sd0)
      && (!right_brake || right_power == 8'sd0))
    else $error("power commanded on a braked motor");

  // Completion is flagged only with both motors stopped.
  a_done_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> left_brake && right_brake)
    else $error("done flagged while a motor drives");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind encoder_move_sequencer ems_port_checks u_ems_port_checks (.*);

### sim/ems_checker.sv
// Checker for the encoder move sequencer: follows both channels, predicts every result beat.
module ems_checker
  import ems_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [15:0] target,
  input  logic               pivot_on_right,
  input  logic signed [31:0] left_encoder,
  input  logic signed [31:0] right_encoder,
  input  logic signed [7:0]  right_power_now,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [7:0]  left_power,
  input  logic signed [7:0]  right_power,
  input  logic               left_brake,
  input  logic               right_brake,
  input  logic               done_res,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Our own copy of the registers and of the sequencer state.
  cfg_t               settings;
  phase_t             move_phase;
  logic signed [31:0] start_angle;
  result_t            commands_due[$];

  // Motor command for one beat; advances the phase and start angle.
  function automatic result_t next_command(item_t it);
    result_t            cmd;
    logic signed [31:0] angle;
    logic [6:0]         speed;
    logic signed [7:0]  pwr;
    longint             delta;
    longint             travel;
    longint             mag;
    logic               reached;
    cmd = '0;
    cmd.left_brake  = 1'b1;
    cmd.right_brake = 1'b1;
    if (it.operation == OP_ABORT) begin
      move_phase = PH_CAPTURE;
      return cmd;
    end
    // A pivot about the right wheel drives and measures the left wheel.
    if (it.operation == OP_PIVOT && it.pivot_on_right) begin
      angle = it.left_encoder;
    end else begin
      angle = it.right_encoder;
    end
    case (move_phase)
      PH_CAPTURE: begin
        start_angle = angle;
        move_phase  = PH_DRIVE;
      end
      PH_DRIVE: begin
        speed = (settings.drive_speed > SPEED_MAX) ? SPEED_MAX : settings.drive_speed;
        pwr   = $signed({1'b0, speed});
        if (!($signed(it.target) > 0)) begin
          pwr = -pwr;
        end
        delta  = longint'($signed(angle)) - longint'($signed(start_angle));
        travel = (delta < 0) ? -delta : delta;
        mag    = longint'($signed(it.target));
        mag    = (mag < 0) ? -mag : mag;
        case (it.operation)
          OP_PIVOT: begin
            reached = DEG_PER_QUARTER * travel >= settings.pivot_counts_per_quarter * mag;
            if (it.pivot_on_right) begin
              cmd.left_power = pwr;
              cmd.left_brake = 1'b0;
            end else begin
              cmd.right_power = pwr;
              cmd.right_brake = 1'b0;
            end
          end
          OP_TURN: begin
            reached = DEG_PER_QUARTER * travel >= settings.turn_counts_per_quarter * mag;
            cmd.left_power  = pwr;
            cmd.right_power = -pwr;
            cmd.left_brake  = 1'b0;
            cmd.right_brake = 1'b0;
          end
          default: begin
            reached = travel * settings.cm_per_count_q16 >= mag * 65536;
            cmd.left_power  = pwr;
            cmd.right_power = pwr;
            cmd.left_brake  = 1'b0;
            cmd.right_brake = 1'b0;
          end
        endcase
        if (reached) begin
          move_phase = PH_BRAKE;
        end
      end
      PH_BRAKE: begin
        if (it.right_power_now == 0) begin
          move_phase = PH_FINISH;
        end
      end
      default: begin
        move_phase   = PH_CAPTURE;
        cmd.done_res = 1'b1;
      end
    endcase
    return cmd;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result beat first, then queue the prediction for a new input beat.
  always @(posedge clk) begin : follow
    item_t   beat;
    result_t seen;
    result_t want;
    if (rst) begin
      settings.drive_speed              = DRIVE_SPEED_RST;
      settings.pivot_counts_per_quarter = PIVOT_COUNTS_RST;
      settings.turn_counts_per_quarter  = TURN_COUNTS_RST;
      settings.cm_per_count_q16         = CM_PER_COUNT_RST;
      move_phase  = PH_CAPTURE;
      start_angle = '0;
      fail_count  = 0;
      commands_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen.left_power  = left_power;
        seen.right_power = right_power;
        seen.left_brake  = left_brake;
        seen.right_brake = right_brake;
        seen.done_res    = done_res;
        if (commands_due.size() == 0) begin
          $error("result beat arrived with no command predicted");
          fail_count++;
        end else begin
          want = commands_due.pop_front();
          check_field("left_power", want.left_power, seen.left_power);
          check_field("right_power", want.right_power, seen.right_power);
          check_field("left_brake", want.left_brake, seen.left_brake);
          check_field("right_brake", want.right_brake, seen.right_brake);
          check_field("done_res", want.done_res, seen.done_res);
        end
      end
      if (in_valid && in_ready) begin
        beat.operation       = op_t'(operation);
        beat.target          = target;
        beat.pivot_on_right  = pivot_on_right;
        beat.left_encoder    = left_encoder;
        beat.right_encoder   = right_encoder;
        beat.right_power_now = right_power_now;
        commands_due.push_back(next_command(beat));
      end
      // Register writes only come while the block is idle.
      if (cfg_write) begin
        case (cfg_index)
          REG_DRIVE_SPEED:  settings.drive_speed              = cfg_data[6:0];
          REG_PIVOT_COUNTS: settings.pivot_counts_per_quarter = cfg_data;
          REG_TURN_COUNTS:  settings.turn_counts_per_quarter  = cfg_data;
          default:          settings.cm_per_count_q16         = cfg_data;
        endcase
      end
    end
    pending = commands_due.size();
  end

endmodule

### sim/testbench.sv
// Top of the encoder move sequencer testbench: clock, reset, move stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ems_pkg::*;

  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 120;
  localparam int PRESSURE_PHASE  = 1;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 4;
  localparam longint TRAVEL_CAP  = 64'sd2147483647;
  localparam logic signed [31:0] ENC_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ENC_MAX = 32'sh7fff_ffff;

  // Register settings and idling per phase; the last phase draws random settings.
  int speed_tab[PHASES] = '{30, 100, 127, 0, 55, 73, 1, 0};
  int pivot_tab[PHASES] = '{180, 180, 0, 65535, 90, 1000, 250, 0};
  int turn_tab[PHASES]  = '{170, 170, 0, 65535, 90, 500, 45, 0};
  int cm_tab[PHASES]    = '{3204, 3204, 65535, 1, 1024, 3204, 0, 0};
  int send_tab[PHASES]  = '{0, 0, 65, 0, 6, 65, 0, 6};
  int stall_tab[PHASES] = '{0, 0, 0, 65, 6, 0, 65, 6};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = REG_DRIVE_SPEED;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         operation = OP_ABORT;
  logic signed [15:0] target = '0;
  logic               pivot_on_right = 1'b0;
  logic signed [31:0] left_encoder = '0;
  logic signed [31:0] right_encoder = '0;
  logic signed [7:0]  right_power_now = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [7:0]  left_power;
  logic signed [7:0]  right_power;
  logic               left_brake;
  logic               right_brake;
  logic               done_res;
  int                 fail_count;
  int                 pending;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_off_req  = 1'b0;
  int items_sent    = 0;
  int quiet_cycles  = 0;
  int cur_pivot     = 180;
  int cur_turn      = 170;
  int cur_cm        = 3204;

  encoder_move_sequencer dut (.*);
  ems_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic item_t item_of(op_t op, logic signed [15:0] tgt, logic right,
                                    logic signed [31:0] lenc, logic signed [31:0] renc,
                                    logic signed [7:0] pwr);
    item_t it;
    it.operation       = op;
    it.target          = tgt;
    it.pivot_on_right  = right;
    it.left_encoder    = lenc;
    it.right_encoder   = renc;
    it.right_power_now = pwr;
    return it;
  endfunction

  function automatic logic signed [7:0] rand_power();
    return 8'(int'($urandom_range(200)) - 100);
  endfunction

  // Places the angle on the encoder that this move measures, noise on the other.
  function automatic item_t at_angle(op_t op, logic signed [15:0] tgt, logic right,
                                     logic signed [31:0] angle, logic signed [7:0] pwr);
    if (op == OP_PIVOT && right) begin
      return item_of(op, tgt, right, angle, $urandom, pwr);
    end
    return item_of(op, tgt, right, $urandom, angle, pwr);
  endfunction

  // Offers one input beat, holds it until accepted, then maybe idles.
  task automatic offer(item_t it);
    in_valid        <= 1'b1;
    operation       <= it.operation;
    target          <= it.target;
    pivot_on_right  <= it.pivot_on_right;
    left_encoder    <= it.left_encoder;
    right_encoder   <= it.right_encoder;
    right_power_now <= it.right_power_now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stops offering and waits until every predicted result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apply_settings(int spd, int piv, int trn, int cm);
    cfg_write <= 1'b1;
    cfg_index <= REG_DRIVE_SPEED;
    cfg_data  <= 16'(spd);
    @(posedge clk);
    cfg_index <= REG_PIVOT_COUNTS;
    cfg_data  <= 16'(piv);
    @(posedge clk);
    cfg_index <= REG_TURN_COUNTS;
    cfg_data  <= 16'(trn);
    @(posedge clk);
    cfg_index <= REG_CM_PER_COUNT;
    cfg_data  <= 16'(cm);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_pivot = piv;
    cur_turn  = trn;
    cur_cm    = cm;
  endtask

  // One whole move: capture, drive toward the threshold, then an abort or brake and finish.
  task automatic run_move();
    op_t                op;
    logic signed [15:0] tgt;
    logic               right;
    longint             mag;
    longint             need;
    longint             travel;
    longint             pos;
    int                 start;
    int                 dir;
    int                 steps;
    int                 nbrake;
    bit                 capped;
    op    = op_t'($urandom_range(OP_STRAIGHT));
    right = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      tgt = 16'($urandom);
    end else begin
      tgt = 16'($urandom_range(400));
      if ($urandom_range(1)) tgt = -tgt;
    end
    mag = longint'(tgt);
    mag = (mag < 0) ? -mag : mag;
    // Encoder travel at which the drive phase should end under the current settings.
    case (op)
      OP_PIVOT: need = (longint'(cur_pivot) * mag + 89) / 90;
      OP_TURN:  need = (longint'(cur_turn) * mag + 89) / 90;
      default: begin
        if (cur_cm == 0) need = (mag == 0) ? 0 : TRAVEL_CAP + 1;
        else need = (mag * 65536 + cur_cm - 1) / cur_cm;
      end
    endcase
    capped = need > TRAVEL_CAP;
    if (capped) need = TRAVEL_CAP;
    start = $urandom;
    dir   = (start >= 0) ? -1 : 1;
    offer(at_angle(op, tgt, right, start, rand_power()));
    steps = (need == 0) ? 1 : $urandom_range(1, 8);
    for (int k = 1; k <= steps; k++) begin
      travel = need * k / steps;
      if (k == steps - 1 && need > 0 && $urandom_range(1)) travel = need - 1;
      if (k == steps && !capped && need < TRAVEL_CAP - 4 && $urandom_range(3) == 0) begin
        travel = travel + $urandom_range(3);
      end
      pos = longint'(start) + dir * travel;
      // Now and then the move itself changes in the middle of the drive.
      if ($urandom_range(19) == 0) begin
        offer(at_angle(op_t'($urandom_range(OP_STRAIGHT)), 16'($urandom),
                       1'($urandom_range(1)), 32'(pos), rand_power()));
      end else begin
        offer(at_angle(op, tgt, right, 32'(pos), rand_power()));
      end
    end
    if (capped || $urandom_range(9) == 0) begin
      offer(item_of(OP_ABORT, 16'($urandom), 1'($urandom_range(1)), $urandom, $urandom,
                    rand_power()));
      return;
    end
    nbrake = $urandom_range(3);
    repeat (nbrake) begin
      offer(at_angle(op, tgt, right, $urandom,
                     8'($urandom_range(1) ? $urandom_range(1, 100)
                                          : -$urandom_range(1, 100))));
    end
    offer(at_angle(op, tgt, right, $urandom, 0));
    offer(at_angle(op, tgt, right, $urandom, rand_power()));
  endtask

  initial begin : stimulus
    int base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed moves with the reset settings.
    offer(item_of(OP_ABORT, 0, 0, 0, 0, 0));
    offer(item_of(OP_PIVOT, 90, 1, ENC_MIN, 12345, 7));
    offer(item_of(OP_PIVOT, 90, 1, ENC_MAX, -1, -100));
    offer(item_of(OP_PIVOT, 90, 1, 0, 0, 100));
    offer(item_of(OP_STRAIGHT, 0, 0, 0, 0, -1));
    offer(item_of(OP_TURN, 0, 0, 0, 0, 0));
    offer(item_of(OP_TURN, 5, 1, -1, 77, 55));
    // Spin turn across the full encoder range with the most negative target.
    offer(item_of(OP_TURN, -32768, 0, 0, ENC_MAX, 0));
    offer(item_of(OP_TURN, -32768, 0, 0, ENC_MIN, 0));
    offer(item_of(OP_ABORT, 32767, 1, -1, -1, -1));
    // Zero target ends the drive on its first beat with negative power.
    offer(item_of(OP_STRAIGHT, 0, 1, 3, -5, 1));
    offer(item_of(OP_STRAIGHT, 0, 0, 0, -5, 1));
    offer(item_of(OP_PIVOT, 0, 0, 0, 0, 0));
    offer(item_of(OP_ABORT, 0, 0, 0, 0, 0));
    // Move changed while driving, ending just past the straight threshold.
    offer(item_of(OP_PIVOT, 32767, 0, 9, 5, 0));
    offer(item_of(OP_PIVOT, 32767, 0, 9, 6, 0));
    offer(item_of(OP_PIVOT, -1, 1, 6, 0, 0));
    offer(item_of(OP_STRAIGHT, 1, 0, 0, 25, 0));
    offer(item_of(OP_STRAIGHT, 1, 0, 0, 26, 0));
    offer(item_of(OP_STRAIGHT, 1, 0, 0, 26, 3));
    offer(item_of(OP_STRAIGHT, 1, 0, 0, 26, 0));
    offer(item_of(OP_STRAIGHT, 1, 0, 0, 26, 0));
    // Abort while driving.
    offer(item_of(OP_TURN, 2, 0, 0, 100, 0));
    offer(item_of(OP_ABORT, -32768, 0, ENC_MIN, ENC_MAX, -100));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        if (p == PHASES - 1) begin
          apply_settings($urandom_range(127), $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(65535));
        end else begin
          apply_settings(speed_tab[p], pivot_tab[p], turn_tab[p], cm_tab[p]);
        end
      end
      send_idle_pct = send_tab[p];
      stall_pct     = stall_tab[p];
      // Long result hold-off while beats keep coming, so the block backs up.
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          offer(item_of(op_t'($urandom_range(OP_ABORT)), 16'($urandom),
                        1'($urandom_range(1)), $urandom, $urandom, rand_power()));
        end else begin
          run_move();
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ems_pkg.sv
rtl/core/ems_travel.sv
rtl/core/ems_ctrl.sv
rtl/core/encoder_move_sequencer.sv
rtl/core/ems_checker.sv
sim/ems_checker.sv
sim/testbench.sv
